// File: hdl/lgc_pkg.sv
// lgc_pkg: shared types, widths and constant log2 tables for the lightmap gamma block
package lgc_pkg;

    // fixed field and datapath widths
    localparam int SAMPLE_W  = 8;
    localparam int EXP_W     = 16;
    localparam int MAG_W     = EXP_W - 1;
    localparam int LOG_FRAC  = 24;
    localparam int MANT_BITS = 30;
    localparam int DEPTH_W   = 28;
    localparam int LIM_W     = 28;
    localparam int PROD_W    = DEPTH_W + MAG_W;
    localparam int TAB_N     = 1 << SAMPLE_W;

    // exponent register after reset (1.0 with twelve fractional bits)
    localparam logic signed [EXP_W-1:0] EXP_RESET = 16'sd4096;

    // all-ones result, the value that a zero or negative exponent yields
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    typedef logic [DEPTH_W-1:0] t_depth_tab [TAB_N];
    typedef logic [LIM_W-1:0]   t_lim_tab   [TAB_N];
    typedef logic               t_ok_tab    [TAB_N];

    // item travelling down the search pipeline
    typedef struct packed {
        logic                sat;
        logic [PROD_W-1:0]   t;
        logic [SAMPLE_W-1:0] r;
    } t_srch;

    // log2 of 1..511 in unsigned q24, truncated, by repeated squaring
    function automatic logic [31:0] log2_q24(input logic [8:0] n);
        logic [63:0] m;
        logic [31:0] res;
        logic [8:0]  nn;
        int          k;
        int          i;
        int          j;
        nn = (n == 9'd0) ? 9'd1 : n;
        k  = 0;
        for (j = 1; j < 9; j++) begin
            if ((nn >> j) != 9'd0) begin
                k = j;
            end
        end
        m   = 64'(nn) << (MANT_BITS - k);
        res = 32'(k) << LOG_FRAC;
        for (i = LOG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> MANT_BITS;
            if (m >= (64'd2 << MANT_BITS)) begin
                m      = m >> 1;
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

    // depth of the base below one: 8 - log2(x + 1)
    function automatic t_depth_tab build_depth_tab();
        t_depth_tab tab;
        int         x;
        for (x = 0; x < TAB_N; x++) begin
            tab[x] = DEPTH_W'((32'd8 << LOG_FRAC) - log2_q24(9'(x + 1)));
        end
        return tab;
    endfunction

    // log2(510) - log2(2k - 1) for every candidate k
    function automatic t_lim_tab build_lim_tab();
        t_lim_tab    tab;
        logic [31:0] l510;
        logic [31:0] lk;
        int          k;
        l510   = log2_q24(9'd510);
        tab[0] = '0;
        for (k = 1; k < TAB_N; k++) begin
            lk     = log2_q24(9'(2 * k - 1));
            tab[k] = (l510 >= lk) ? LIM_W'(l510 - lk) : '0;
        end
        return tab;
    endfunction

    // candidate k usable at all (log2(510) not below log2(2k - 1))
    function automatic t_ok_tab build_ok_tab();
        t_ok_tab     tab;
        logic [31:0] l510;
        int          k;
        l510   = log2_q24(9'd510);
        tab[0] = 1'b0;
        for (k = 1; k < TAB_N; k++) begin
            tab[k] = (l510 >= log2_q24(9'(2 * k - 1)));
        end
        return tab;
    endfunction

    localparam t_depth_tab DEPTH_TAB = build_depth_tab();
    localparam t_lim_tab   LIM_TAB   = build_lim_tab();
    localparam t_ok_tab    OK_TAB    = build_ok_tab();

endpackage

// File: hdl/lightmap_gamma_correct_core.sv
// lightmap_gamma_correct_core: top level, exponent register and ten-stage power-law pipeline
//
// Input items carry one lightmap colour byte on i_sample_in (i_in_valid / o_in_ready);
// result items carry round(255 * ((x + 1) / 256) ^ e) on o_sample_out
// (o_out_valid / i_out_ready). An item moves on a rising edge with valid and ready high.
// The exponent e is written through i_cfg_valid / o_cfg_ready with i_exponent_q12,
// signed, EXPONENT_FRAC_BITS fractional bits; write it only while no item is in flight.
// A zero or negative exponent gives 255 for every item.
// Pipeline: one stage looks up the depth of the base below one (-log2 of the base),
// one multiplies it by the exponent, and eight stages each settle one result bit
// of a binary search against constant log2 thresholds.
// Throughput: one item per cycle when not stalled; each stage holds one item and the
// lookup, the 28 x 15 bit multiplier and each threshold compare are used once per item.
// Reset (synchronous, i_rst_n low) empties the pipeline and sets the exponent to 1.0.
// When the receiver stalls, the output stage holds its item; stages upstream keep
// filling their empty slots, so o_in_ready drops only once the whole pipeline is full.
module lightmap_gamma_correct_core
    import lgc_pkg::*;
#(
    parameter int EXPONENT_FRAC_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic signed [EXP_W-1:0]    i_exponent_q12,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [SAMPLE_W-1:0]        i_sample_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [SAMPLE_W-1:0]        o_sample_out
);

    localparam int N_BITS = SAMPLE_W;

    logic signed [EXP_W-1:0] r_exponent;

    logic  stg_valid [N_BITS+1];
    logic  stg_ready [N_BITS+1];
    t_srch stg_data  [N_BITS+1];

    // exponent register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= EXP_RESET;
        end else if (i_cfg_valid) begin
            r_exponent <= i_exponent_q12;
        end
    end

    // lookup and multiply
    lgc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_exponent (r_exponent),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_sample   (i_sample_in),
        .o_valid    (stg_valid[0]),
        .i_ready    (stg_ready[0]),
        .o_data     (stg_data[0])
    );

    // binary search, most significant result bit first
    for (genvar g = 0; g < N_BITS; g++) begin : g_srch
        lgc_srch_stage #(
            .FRAC_BITS (EXPONENT_FRAC_BITS),
            .BIT_POS   (N_BITS - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    // output side
    assign stg_ready[N_BITS] = i_out_ready;
    assign o_out_valid       = stg_valid[N_BITS];
    assign o_sample_out      = stg_data[N_BITS].r;

endmodule

// File: hdl/lgc_front.sv
// lgc_front: log-depth lookup and exponent multiply, two pipeline stages
module lgc_front
    import lgc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic signed [EXP_W-1:0]    i_exponent,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [SAMPLE_W-1:0]        i_sample,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_srch                      o_data
);

    logic               r_a_valid;
    logic [DEPTH_W-1:0] r_a_depth;
    logic [MAG_W-1:0]   r_a_mag;
    logic               r_a_sat;
    logic               a_ready;

    logic               r_b_valid;
    t_srch              r_b_data;
    logic               b_ready;

    // stalls ripple back only where a stage is full
    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // stage a: table lookup of the depth, exponent split into magnitude and saturate flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (a_ready && i_valid) begin
            r_a_depth <= DEPTH_TAB[i_sample];
            r_a_mag   <= i_exponent[MAG_W-1:0];
            r_a_sat   <= (i_exponent == '0) || i_exponent[EXP_W-1];
        end
    end

    // stage b: scaled depth t = depth * exponent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (b_ready && r_a_valid) begin
            r_b_data.sat <= r_a_sat;
            r_b_data.t   <= PROD_W'(r_a_depth) * PROD_W'(r_a_mag);
            r_b_data.r   <= '0;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

// File: hdl/lgc_srch_stage.sv
// lgc_srch_stage: one result bit of the binary search, compared in the log domain
module lgc_srch_stage
    import lgc_pkg::*;
#(
    parameter int FRAC_BITS = 12,
    parameter int BIT_POS   = 7
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_srch i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_srch o_data
);

    localparam int CMP_W = (PROD_W > LIM_W + FRAC_BITS) ? PROD_W : LIM_W + FRAC_BITS;

    logic                r_valid;
    t_srch               r_data;
    logic [SAMPLE_W-1:0] cand;
    logic [CMP_W-1:0]    bound;
    logic                hit;

    // candidate with this bit set; keep it if sat or if usable and t <= threshold
    always_comb begin
        cand  = i_data.r | (SAMPLE_W'(1) << BIT_POS);
        bound = CMP_W'(LIM_TAB[cand]) << FRAC_BITS;
        hit   = i_data.sat || (OK_TAB[cand] && (CMP_W'(i_data.t) <= bound));
    end

    assign o_ready = !r_valid || i_ready;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data.sat <= i_data.sat;
            r_data.t   <= i_data.t;
            r_data.r   <= hit ? cand : i_data.r;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
